[design/slrg_pkg.sv]
// ----------------------------------------------------------------------------
// slrg_pkg
// Shared constants and types of the shuffled Lehmer random generator:
// generator constants, table geometry and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package slrg_pkg;

    localparam int TABLE_SIZE = 32;
    localparam int TBL_AW     = $clog2(TABLE_SIZE);
    localparam int INIT_STEPS = TABLE_SIZE + 8;
    localparam int CNT_W      = $clog2(INIT_STEPS);

    localparam int SEED_W     = 32;
    localparam int INT_W      = 31;
    localparam int FRAC_W     = 24;
    localparam int MUL_W      = 15;
    localparam int PROD_W     = SEED_W + MUL_W - 1;
    localparam int SHUF_SHIFT = INT_W - TBL_AW;
    localparam int FRAC_LOW   = INT_W - FRAC_W;

    localparam logic [MUL_W-1:0]  LCG_MUL  = MUL_W'(16807);
    localparam logic [SEED_W-1:0] LCG_MOD  = SEED_W'(2147483647);
    localparam logic [FRAC_W:0]   FRAC_MAX = (FRAC_W + 1)'(16777214);

    typedef struct packed {
        logic              take;
        logic              mul;
        logic              red;
        logic              fill;
        logic              set_last;
        logic              draw;
        logic [TBL_AW-1:0] fill_idx;
    } cmd_t;

    typedef struct packed {
        logic need_init;
    } status_t;

endpackage

[design/slrg_in_if.sv]
// ----------------------------------------------------------------------------
// slrg_in_if
// Request channel: valid/ready handshake with the seed and restart controls.
// ----------------------------------------------------------------------------
interface slrg_in_if
    import slrg_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     load_seed;
    logic signed [SEED_W-1:0] seed_value;
    logic                     restart;

    modport source (output valid, output load_seed, output seed_value, output restart,
                    input ready);
    modport sink   (input valid, input load_seed, input seed_value, input restart,
                    output ready);
endinterface

[design/slrg_out_if.sv]
// ----------------------------------------------------------------------------
// slrg_out_if
// Result channel: valid/ready handshake with the integer and Q0.24 outputs.
// ----------------------------------------------------------------------------
interface slrg_out_if
    import slrg_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [INT_W-1:0]  random_int;
    logic [FRAC_W-1:0] random_fraction;

    modport source (output valid, output random_int, output random_fraction,
                    input ready);
    modport sink   (input valid, input random_int, input random_fraction,
                    output ready);
endinterface

[design/shuffled_lehmer_random_generator_unit.sv]
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator_unit
// Minimal-standard Lehmer generator behind a 32-entry shuffle table.
// ----------------------------------------------------------------------------
// Each request item yields one result item. A plain draw passes from
// acceptance through the seed register and the product register into the
// result register: one generator step is a registered multiply by 16807
// followed by a modulo 2^31-1 fold, and the table entry is read in the
// multiply cycle and rewritten in the fold cycle. The request side reopens
// only once the result is registered, so a new item is not taken while the
// last one is still in its step. When the item reseeds (seed at most zero,
// first use after reset, or restart set) the 40-step table fill runs first
// on the same step unit. The next request is taken as soon as the result
// is registered, even while it still waits on the result channel; that
// next item then holds in its fold cycle until the waiting result is taken.
// ----------------------------------------------------------------------------
module shuffled_lehmer_random_generator_unit
    import slrg_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    slrg_in_if.sink    request,
    slrg_out_if.source result
);

    cmd_t    cmd;
    status_t status;

    slrg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    slrg_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .load_seed       (request.load_seed),
        .seed_value      (request.seed_value),
        .restart         (request.restart),
        .random_int      (result.random_int),
        .random_fraction (result.random_fraction)
    );

endmodule

[design/slrg_ram.sv]
// ----------------------------------------------------------------------------
// slrg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slrg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/slrg_ctrl.sv]
// ----------------------------------------------------------------------------
// slrg_ctrl
// Sequencer: accepts an item, runs the table fill when needed, then one
// draw step, and owns the result valid flag.
// ----------------------------------------------------------------------------
module slrg_ctrl
    import slrg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT_MUL,
        ST_INIT_RED,
        ST_DRAW_MUL,
        ST_DRAW_RED
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.fill_idx   = cnt_reg[TBL_AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.take = 1'b1;
                    if (status.need_init)
                    begin
                        cnt_next   = CNT_W'(INIT_STEPS - 1);
                        state_next = ST_INIT_MUL;
                    end
                    else
                    begin
                        state_next = ST_DRAW_MUL;
                    end
                end
            end
            ST_INIT_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_INIT_RED;
            end
            ST_INIT_RED:
            begin
                cmd.red  = 1'b1;
                cmd.fill = (cnt_reg < CNT_W'(TABLE_SIZE));
                if (cnt_reg == '0)
                begin
                    cmd.set_last = 1'b1;
                    state_next   = ST_DRAW_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_INIT_MUL;
                end
            end
            ST_DRAW_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DRAW_RED;
            end
            ST_DRAW_RED:
            begin
                if (slot_free)
                begin
                    cmd.red        = 1'b1;
                    cmd.draw       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[design/slrg_dp.sv]
// ----------------------------------------------------------------------------
// slrg_dp
// Datapath: seed register, constant multiply and modulo reduction, shuffle
// table, last output and the result registers with the Q0.24 scaling.
// ----------------------------------------------------------------------------
module slrg_dp
    import slrg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output status_t                  status,
    input  logic                     load_seed,
    input  logic signed [SEED_W-1:0] seed_value,
    input  logic                     restart,
    output logic [INT_W-1:0]         random_int,
    output logic [FRAC_W-1:0]        random_fraction
);

    logic [SEED_W-1:0] seed_reg, seed_next;
    logic [INT_W-1:0]  last_reg, last_next;
    logic [PROD_W-1:0] prod_reg;
    logic [INT_W-1:0]  int_reg;
    logic [FRAC_W-1:0] frac_reg;

    logic [SEED_W-1:0] eff_seed;
    logic [SEED_W-1:0] neg_seed;
    logic [SEED_W-1:0] init_seed;
    logic [SEED_W-1:0] red_sum;
    logic [INT_W-1:0]  red_val;
    logic [TBL_AW-1:0] shuf_idx;
    logic [INT_W-1:0]  ram_rdata;
    logic [SEED_W-1:0] frac_rem;
    logic [FRAC_W:0]   frac_q;
    logic [FRAC_W-1:0] frac_val;

    // seed for this item and the restart value of the fill
    always_comb
    begin
        eff_seed = load_seed ? SEED_W'(seed_value) : seed_reg;
        neg_seed = SEED_W'(0) - eff_seed;
        if (!eff_seed[SEED_W-1] && (eff_seed != '0))
        begin
            init_seed = SEED_W'(1);
        end
        else if (neg_seed == '0)
        begin
            init_seed = SEED_W'(1);
        end
        else
        begin
            init_seed = neg_seed;
        end
        status.need_init = (eff_seed == '0) || eff_seed[SEED_W-1] ||
                           (last_reg == '0) || restart;
    end

    // fold the product modulo 2^31 - 1
    always_comb
    begin
        red_sum = {1'b0, prod_reg[INT_W-1:0]} + SEED_W'(prod_reg[PROD_W-1:INT_W]);
        if (red_sum >= LCG_MOD)
        begin
            red_val = INT_W'(red_sum - LCG_MOD);
        end
        else
        begin
            red_val = red_sum[INT_W-1:0];
        end
    end

    assign shuf_idx = last_reg[INT_W-1:SHUF_SHIFT];

    // floor(x * 2^24 / (2^31 - 1)) with one correction step, then clamp
    always_comb
    begin
        frac_rem = {1'b0, ram_rdata[FRAC_LOW-1:0], FRAC_W'(0)} +
                   SEED_W'(ram_rdata[INT_W-1:FRAC_LOW]);
        frac_q   = {1'b0, ram_rdata[INT_W-1:FRAC_LOW]} +
                   (FRAC_W + 1)'(frac_rem >= LCG_MOD);
        frac_val = (frac_q > FRAC_MAX) ? FRAC_MAX[FRAC_W-1:0] : frac_q[FRAC_W-1:0];
    end

    always_comb
    begin
        seed_next = seed_reg;
        if (cmd.take)
        begin
            seed_next = status.need_init ? init_seed : eff_seed;
        end
        else if (cmd.red)
        begin
            seed_next = {1'b0, red_val};
        end
        last_next = last_reg;
        if (cmd.set_last)
        begin
            last_next = red_val;
        end
        else if (cmd.draw)
        begin
            last_next = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            last_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(seed_reg) * PROD_W'(LCG_MUL);
        end
        if (cmd.draw)
        begin
            int_reg  <= ram_rdata;
            frac_reg <= frac_val;
        end
    end

    slrg_ram #(
        .WIDTH (INT_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (cmd.fill || cmd.draw),
        .waddr (cmd.draw ? shuf_idx : cmd.fill_idx),
        .wdata (red_val),
        .raddr (shuf_idx),
        .rdata (ram_rdata)
    );

    assign random_int      = int_reg;
    assign random_fraction = frac_reg;

endmodule
